>>> hw/rtl/fpagc_pkg.sv
// Package with shared constants and types of the frame peak gain control block.
package fpagc_pkg;

    localparam int LANES      = 4;
    localparam int FRAME_MAX  = 160;
    localparam int HISTORY    = 32;

    localparam int SAMPLE_W   = 24;
    localparam int PCM_W      = 16;
    localparam int LEVEL_W    = 15;
    localparam int GAIN_W     = 22;
    localparam int RISE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;

    localparam int LANE_CNT_W = $clog2(LANES + 1);
    localparam int LANE_IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int FILL_W     = $clog2(FRAME_MAX + 1);
    localparam int ADDR_W     = $clog2(FRAME_MAX);
    localparam int HIST_W     = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int HCNT_W     = $clog2(HISTORY + 1);

    localparam int DIVD_W     = LEVEL_W + 24;
    localparam int DIVS_W     = SAMPLE_W;
    localparam int DCNT_W     = $clog2(DIVD_W);

    localparam logic [LEVEL_W-1:0] TARGET_LEVEL_RST  = LEVEL_W'(30000);
    localparam logic [GAIN_W-1:0]  MAX_GAIN_RST      = GAIN_W'(3276800);
    localparam logic [RISE_W-1:0]  RISE_FRACTION_RST = RISE_W'(3277);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_LEVEL  = 2'd0,
        REG_MAX_GAIN      = 2'd1,
        REG_RISE_FRACTION = 2'd2,
        REG_UNUSED        = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FINISH,
        ST_SCAN,
        ST_DIV_T,
        ST_GAIN,
        ST_DIV_R,
        ST_EMIT_RD,
        ST_EMIT_MUL,
        ST_EMIT_SAT
    } state_t;

endpackage

>>> hw/rtl/frame_peak_agc_int16_top.sv
// Top level of the frame peak automatic gain control with 16 bit output.
//
// Usage: an input transaction is taken at a rising edge where start is high and
// busy is low. It carries up to four signed Q15.8 samples (lanes_used counts
// them from lane 0, values above four count as four) and frame_end. Samples
// are written into the frame store one per cycle, and busy stays high at least
// until all are written. Samples past the frame store depth are dropped.
// On a transaction with frame_end set and samples stored, the block records the
// frame peak in the history ring, scans the ring (one entry per cycle), divides
// the target level by the ring maximum and then the gain ramp step by the frame
// length, both on one shared restoring divider that produces one quotient bit
// per cycle. The frame is then replayed through a single multiplier, each
// sample read, multiplied and saturated before the next is read, and each
// group of up to four gained samples leaves as one result transaction, marked
// by pcm_valid for exactly one cycle; pcm_last flags the final result of the
// frame. The receiver cannot stall the block.
// Configuration writes are taken whenever cfg_valid is high (cfg_ready stays
// high) and must be issued only while the block is idle.
// Reset clears the ring, the fill count and the history pointer, reloads the
// held gain and the registers with their defaults, and aborts any frame.
module frame_peak_agc_int16_top
    import fpagc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [SAMPLE_W-1:0]   sample_0,
    input  logic signed [SAMPLE_W-1:0]   sample_1,
    input  logic signed [SAMPLE_W-1:0]   sample_2,
    input  logic signed [SAMPLE_W-1:0]   sample_3,
    input  logic        [2:0]            lanes_used,
    input  logic                         frame_end,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_data,
    output logic                         pcm_valid,
    output logic signed [PCM_W-1:0]      pcm_0,
    output logic signed [PCM_W-1:0]      pcm_1,
    output logic signed [PCM_W-1:0]      pcm_2,
    output logic signed [PCM_W-1:0]      pcm_3,
    output logic        [2:0]            pcm_lanes,
    output logic                         pcm_last
);

    // Configuration registers.
    logic [LEVEL_W-1:0] target_level_reg;
    logic [GAIN_W-1:0]  max_gain_reg;
    logic [RISE_W-1:0]  rise_fraction_reg;

    // Sequencer and datapath registers.
    state_t                   state_reg, state_next;
    logic [SAMPLE_W-1:0]      lat_reg [LANES];
    logic [SAMPLE_W-1:0]      lat_next [LANES];
    logic [LANE_CNT_W-1:0]    lanes_reg, lanes_next;
    logic                     fend_reg, fend_next;
    logic [LANE_CNT_W-1:0]    lane_reg, lane_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [FILL_W-1:0]        n_reg, n_next;
    logic [SAMPLE_W-1:0]      peak_reg, peak_next;
    logic [HIST_W-1:0]        hptr_reg, hptr_next;
    logic [HCNT_W-1:0]        hcnt_reg, hcnt_next;
    logic [SAMPLE_W-1:0]      rmax_reg, rmax_next;
    logic [GAIN_W-1:0]        held_reg, held_next;
    logic signed [GAIN_W+1:0] delta_reg, delta_next;
    logic [DIVD_W-1:0]        quo_reg, quo_next;
    logic [DIVS_W-1:0]        rem_reg, rem_next;
    logic [DIVS_W-1:0]        den_reg, den_next;
    logic [DCNT_W-1:0]        dcnt_reg, dcnt_next;
    logic [FILL_W-1:0]        idx_reg, idx_next;
    logic [GAIN_W:0]          accq_reg, accq_next;
    logic [FILL_W-1:0]        accr_reg, accr_next;
    logic [SAMPLE_W-1:0]      rd_reg;
    logic [2*GAIN_W+1:0]      prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic                     valid_reg, valid_next;
    logic [PCM_W-1:0]         pcm_reg [LANES];
    logic [PCM_W-1:0]         pcm_next [LANES];
    logic [2:0]               plan_reg, plan_next;
    logic                     plast_reg, plast_next;

    // Frame store and peak history.
    logic [SAMPLE_W-1:0] frame_mem [FRAME_MAX];
    logic [SAMPLE_W-1:0] ring_reg [HISTORY];
    logic                mem_we;
    logic                ring_we;

    // Combinational helpers.
    logic [SAMPLE_W-1:0]     cur_sample;
    logic [SAMPLE_W-1:0]     cur_mag;
    logic [SAMPLE_W-1:0]     rd_mag;
    logic [DIVS_W:0]         div_shift;
    logic                    div_ge;
    logic [DIVS_W:0]         div_sub;
    logic [GAIN_W+RISE_W-1:0] lim_prod;
    logic [GAIN_W-1:0]       limit;
    logic [GAIN_W-1:0]       capped;
    logic signed [GAIN_W+1:0] diff;
    logic signed [GAIN_W+1:0] lim_s;
    logic [GAIN_W-1:0]       ramp_gain;
    logic [FILL_W:0]         rsum;
    logic [GAIN_W-1:0]       qmag;
    logic [PCM_W-1:0]        sat_val;
    logic                    last_s;
    logic [2:0]              clamp_lanes;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);
    assign pcm_valid = valid_reg;
    assign pcm_0     = pcm_reg[0];
    assign pcm_1     = pcm_reg[1];
    assign pcm_2     = pcm_reg[2];
    assign pcm_3     = pcm_reg[3];
    assign pcm_lanes = plan_reg;
    assign pcm_last  = plast_reg;

    assign clamp_lanes = (lanes_used > 3'(LANES)) ? 3'(LANES) : lanes_used;

    assign cur_sample = lat_reg[lane_reg[LANE_IDX_W-1:0]];
    assign cur_mag    = cur_sample[SAMPLE_W-1] ? (~cur_sample + 1'b1) : cur_sample;
    assign rd_mag     = rd_reg[SAMPLE_W-1] ? (~rd_reg + 1'b1) : rd_reg;

    // One restoring divider step: one quotient bit per cycle.
    assign div_shift = {rem_reg, quo_reg[DIVD_W-1]};
    assign div_ge    = (div_shift >= {1'b0, den_reg});
    assign div_sub   = div_shift - {1'b0, den_reg};

    // Rise limit is the fraction of the held gain, Q0.16 times Q6.16.
    assign lim_prod = rise_fraction_reg * held_reg;
    assign limit    = lim_prod[GAIN_W+RISE_W-1:RISE_W];
    assign capped   = (quo_reg > DIVD_W'(max_gain_reg)) ? max_gain_reg
                                                       : quo_reg[GAIN_W-1:0];
    assign diff     = $signed({2'b00, capped}) - $signed({2'b00, held_reg});
    assign lim_s    = $signed({2'b00, limit});

    assign ramp_gain = delta_reg[GAIN_W+1] ? (held_reg - accq_reg[GAIN_W-1:0])
                                           : (held_reg + accq_reg[GAIN_W-1:0]);
    assign rsum      = {1'b0, accr_reg} + {1'b0, rem_reg[FILL_W-1:0]};

    // Truncated product and int16 saturation.
    assign qmag = prod_reg[2*GAIN_W+1:24];
    always_comb
    begin
        if (neg_reg)
        begin
            sat_val = (qmag > GAIN_W'(32768)) ? 16'h8000 : 16'(~qmag + 1'b1);
        end
        else
        begin
            sat_val = (qmag > GAIN_W'(32767)) ? 16'h7FFF : qmag[PCM_W-1:0];
        end
    end

    assign last_s = ((idx_reg + 1'b1) == n_reg);

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_level_reg  <= TARGET_LEVEL_RST;
            max_gain_reg      <= MAX_GAIN_RST;
            rise_fraction_reg <= RISE_FRACTION_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TARGET_LEVEL:  target_level_reg  <= cfg_data[LEVEL_W-1:0];
                REG_MAX_GAIN:      max_gain_reg      <= cfg_data[GAIN_W-1:0];
                REG_RISE_FRACTION: rise_fraction_reg <= cfg_data[RISE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Frame store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[fill_reg[ADDR_W-1:0]] <= cur_sample;
        end
        rd_reg <= frame_mem[idx_reg[ADDR_W-1:0]];
    end

    // Peak history ring, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int h = 0; h < HISTORY; h++)
            begin
                ring_reg[h] <= '0;
            end
        end
        else if (ring_we)
        begin
            ring_reg[hptr_reg] <= peak_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            hptr_reg  <= '0;
            held_reg  <= MAX_GAIN_RST;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            hptr_reg  <= hptr_next;
            held_reg  <= held_next;
            valid_reg <= valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        lat_reg   <= lat_next;
        lanes_reg <= lanes_next;
        fend_reg  <= fend_next;
        lane_reg  <= lane_next;
        n_reg     <= n_next;
        peak_reg  <= peak_next;
        hcnt_reg  <= hcnt_next;
        rmax_reg  <= rmax_next;
        delta_reg <= delta_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        dcnt_reg  <= dcnt_next;
        idx_reg   <= idx_next;
        accq_reg  <= accq_next;
        accr_reg  <= accr_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        pcm_reg   <= pcm_next;
        plan_reg  <= plan_next;
        plast_reg <= plast_next;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        lat_next   = lat_reg;
        lanes_next = lanes_reg;
        fend_next  = fend_reg;
        lane_next  = lane_reg;
        fill_next  = fill_reg;
        n_next     = n_reg;
        peak_next  = peak_reg;
        hptr_next  = hptr_reg;
        hcnt_next  = hcnt_reg;
        rmax_next  = rmax_reg;
        held_next  = held_reg;
        delta_next = delta_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        dcnt_next  = dcnt_reg;
        idx_next   = idx_reg;
        accq_next  = accq_reg;
        accr_next  = accr_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        pcm_next   = pcm_reg;
        plan_next  = plan_reg;
        plast_next = plast_reg;
        valid_next = 1'b0;
        mem_we     = 1'b0;
        ring_we    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    lat_next[0] = sample_0;
                    lat_next[1] = sample_1;
                    lat_next[2] = sample_2;
                    lat_next[3] = sample_3;
                    lanes_next  = LANE_CNT_W'(clamp_lanes);
                    fend_next   = frame_end;
                    lane_next   = '0;
                    state_next  = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                if (lane_reg == lanes_reg)
                begin
                    state_next = fend_reg ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    if (fill_reg < FILL_W'(FRAME_MAX))
                    begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                        if ((fill_reg == '0) || (cur_mag > peak_reg))
                        begin
                            peak_next = cur_mag;
                        end
                    end
                    lane_next = lane_reg + 1'b1;
                end
            end

            ST_FINISH:
            begin
                n_next    = fill_reg;
                fill_next = '0;
                if (fill_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ring_we    = 1'b1;
                    hptr_next  = (hptr_reg == HIST_W'(HISTORY - 1)) ? '0 : hptr_reg + 1'b1;
                    hcnt_next  = '0;
                    rmax_next  = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (hcnt_reg == HCNT_W'(HISTORY))
                begin
                    rem_next  = '0;
                    dcnt_next = '0;
                    den_next  = rmax_reg;
                    if (rmax_reg == '0)
                    begin
                        quo_next   = DIVD_W'(max_gain_reg);
                        state_next = ST_GAIN;
                    end
                    else
                    begin
                        quo_next   = {target_level_reg, 24'd0};
                        state_next = ST_DIV_T;
                    end
                end
                else
                begin
                    if (ring_reg[hcnt_reg[HIST_W-1:0]] > rmax_reg)
                    begin
                        rmax_next = ring_reg[hcnt_reg[HIST_W-1:0]];
                    end
                    hcnt_next = hcnt_reg + 1'b1;
                end
            end

            ST_DIV_T, ST_DIV_R:
            begin
                rem_next  = div_ge ? div_sub[DIVS_W-1:0] : div_shift[DIVS_W-1:0];
                quo_next  = {quo_reg[DIVD_W-2:0], div_ge};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIVD_W - 1))
                begin
                    if (state_reg == ST_DIV_T)
                    begin
                        state_next = ST_GAIN;
                    end
                    else
                    begin
                        idx_next   = '0;
                        lane_next  = '0;
                        accq_next  = '0;
                        accr_next  = '0;
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            ST_GAIN:
            begin
                if (quo_reg < DIVD_W'(held_reg))
                begin
                    held_next  = quo_reg[GAIN_W-1:0];
                    delta_next = '0;
                    quo_next   = '0;
                end
                else
                begin
                    delta_next = (diff > lim_s) ? lim_s : diff;
                    quo_next   = DIVD_W'((diff > lim_s) ? 24'(lim_s) :
                                         (diff[GAIN_W+1] ? 24'(-diff) : 24'(diff)));
                end
                rem_next   = '0;
                dcnt_next  = '0;
                den_next   = DIVS_W'(n_reg);
                state_next = ST_DIV_R;
            end

            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_MUL;
            end

            ST_EMIT_MUL:
            begin
                prod_next = (2*GAIN_W+2)'(rd_mag) * (2*GAIN_W+2)'(ramp_gain);
                neg_next  = rd_reg[SAMPLE_W-1];
                if (rsum >= {1'b0, n_reg})
                begin
                    accr_next = FILL_W'(rsum - {1'b0, n_reg});
                    accq_next = accq_reg + quo_reg[GAIN_W:0] + 1'b1;
                end
                else
                begin
                    accr_next = rsum[FILL_W-1:0];
                    accq_next = accq_reg + quo_reg[GAIN_W:0];
                end
                state_next = ST_EMIT_SAT;
            end

            ST_EMIT_SAT:
            begin
                if (lane_reg == '0)
                begin
                    for (int k = 0; k < LANES; k++)
                    begin
                        pcm_next[k] = '0;
                    end
                end
                pcm_next[lane_reg[LANE_IDX_W-1:0]] = sat_val;
                idx_next = idx_reg + 1'b1;
                if (last_s || (lane_reg == LANE_CNT_W'(LANES - 1)))
                begin
                    valid_next = 1'b1;
                    plan_next  = 3'(lane_reg + 1'b1);
                    plast_next = last_s;
                    lane_next  = '0;
                end
                else
                begin
                    lane_next = lane_reg + 1'b1;
                end
                if (last_s)
                begin
                    held_next  = GAIN_W'(24'($signed({2'b00, held_reg}) + delta_reg));
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/fpagc_chk.sv
// Port-level checker for the frame peak gain control block and its bind.
module fpagc_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       pcm_valid,
    input logic [2:0] pcm_lanes,
    input logic       pcm_last
);

    // An accepted transaction always makes the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Every result carries between one and four samples.
    assert property (@(posedge clk) disable iff (!rst_n)
        pcm_valid |-> (pcm_lanes != 3'd0) && (pcm_lanes <= 3'd4))
        else $error("result lane count out of range");

    // Results are spaced apart, so two strobes never come back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        pcm_valid |=> !pcm_valid)
        else $error("result strobe held for two cycles");

    // A result that is not the last of its frame leaves the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pcm_valid && !pcm_last) |-> busy)
        else $error("frame emission stopped before its last result");

endmodule

bind frame_peak_agc_int16_top fpagc_chk u_fpagc_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .pcm_valid (pcm_valid),
    .pcm_lanes (pcm_lanes),
    .pcm_last  (pcm_last)
);

>>> sim/frame_peak_agc_int16_top_test.sv
// Self-checking testbench for the frame peak automatic gain control block.
module frame_peak_agc_int16_top_test;
    import fpagc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Drain wait, long enough for the frame end of a full frame of 160 samples
    // to reach its last result.
    localparam int DRAIN_CYCLES = 700;
    localparam int MAX_REPORTS  = 10;

    // One input transaction as the sender sees it.
    typedef struct {
        logic signed [SAMPLE_W-1:0] smp [LANES];
        logic [2:0]                 lanes;
        logic                       last;
    } audio_item_t;

    // One result transaction as the receiver sees it.
    typedef struct {
        logic signed [PCM_W-1:0] pcm [LANES];
        logic [2:0]              lanes;
        logic                    last;
    } pcm_item_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic signed [SAMPLE_W-1:0]   sample_0 = '0;
    logic signed [SAMPLE_W-1:0]   sample_1 = '0;
    logic signed [SAMPLE_W-1:0]   sample_2 = '0;
    logic signed [SAMPLE_W-1:0]   sample_3 = '0;
    logic [2:0]                   lanes_used = '0;
    logic                         frame_end = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;
    logic                         pcm_valid;
    logic signed [PCM_W-1:0]      pcm_0;
    logic signed [PCM_W-1:0]      pcm_1;
    logic signed [PCM_W-1:0]      pcm_2;
    logic signed [PCM_W-1:0]      pcm_3;
    logic [2:0]                   pcm_lanes;
    logic                         pcm_last;

    frame_peak_agc_int16_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .sample_0   (sample_0),
        .sample_1   (sample_1),
        .sample_2   (sample_2),
        .sample_3   (sample_3),
        .lanes_used (lanes_used),
        .frame_end  (frame_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pcm_valid  (pcm_valid),
        .pcm_0      (pcm_0),
        .pcm_1      (pcm_1),
        .pcm_2      (pcm_2),
        .pcm_3      (pcm_3),
        .pcm_lanes  (pcm_lanes),
        .pcm_last   (pcm_last)
    );

    always #2 clk = ~clk;

    // Shadow copy of the block's registers and state, kept by the predictor.
    longint unsigned agc_target_level;
    longint unsigned agc_max_gain;
    longint unsigned agc_rise_fraction;
    longint          frame_samples [FRAME_MAX];
    longint unsigned peak_ring [HISTORY];
    int unsigned     ring_wr_ptr;
    longint unsigned gain_now;
    int unsigned     frame_fill;

    pcm_item_t expected_pcm_q [$];
    int        mismatch_count = 0;

    // Applies a gain in Q6.16 (plus eight fraction bits of the Q15.8 input) to
    // one sample, truncating toward zero and saturating to 16 bits.
    function automatic logic signed [PCM_W-1:0] apply_gain(longint s, longint g);
        longint unsigned mag;
        longint unsigned q;
        mag = (s < 0) ? longint'(-s) : longint'(s);
        q = (mag * longint'(g)) >> 24;
        if (s < 0)
            return (q > 32768) ? -16'sd32768 : PCM_W'(-longint'(q));
        return (q > 32767) ? 16'sd32767 : PCM_W'(q);
    endfunction

    // Folds one accepted input transaction into the shadow state and queues
    // every result transaction that the frame end releases.
    task automatic predict_frame(input audio_item_t it);
        int unsigned     n_lanes;
        int unsigned     n;
        int unsigned     cnt;
        longint unsigned peak;
        longint unsigned ring_max;
        longint unsigned gain_target;
        longint unsigned abs_delta;
        longint          delta;
        longint          ramp_limit;
        longint          term;
        longint          m;
        pcm_item_t       res;
        n_lanes = (it.lanes > LANES) ? LANES : it.lanes;
        for (int i = 0; i < n_lanes; i++)
        begin
            if (frame_fill < FRAME_MAX)
            begin
                frame_samples[frame_fill] = longint'(it.smp[i]);
                frame_fill++;
            end
        end
        if (!it.last)
            return;
        n = frame_fill;
        frame_fill = 0;
        // A frame end with nothing stored leaves the gain and the ring alone.
        if (n == 0)
            return;

        peak = 0;
        for (int i = 0; i < n; i++)
        begin
            m = (frame_samples[i] < 0) ? -frame_samples[i] : frame_samples[i];
            if (m > peak)
                peak = m;
        end
        peak_ring[ring_wr_ptr] = peak;
        ring_wr_ptr = (ring_wr_ptr + 1) % HISTORY;
        ring_max = 0;
        foreach (peak_ring[h])
            if (peak_ring[h] > ring_max)
                ring_max = peak_ring[h];

        if (ring_max == 0)
            gain_target = agc_max_gain;
        else
            gain_target = (agc_target_level << 24) / ring_max;

        // A drop takes effect at once; otherwise the target is capped, and a rise is rate limited.
        delta = 0;
        if (gain_target < gain_now)
        begin
            gain_now = gain_target;
        end
        else
        begin
            if (gain_target > agc_max_gain)
                gain_target = agc_max_gain;
            delta = longint'(gain_target) - longint'(gain_now);
            ramp_limit = longint'((agc_rise_fraction * gain_now) >> 16);
            if (delta > ramp_limit)
                delta = ramp_limit;
        end
        abs_delta = (delta < 0) ? -delta : delta;

        for (int i = 0; i < n; i += LANES)
        begin
            cnt = (n - i > LANES) ? LANES : n - i;
            for (int j = 0; j < LANES; j++)
            begin
                res.pcm[j] = '0;
                if (j < cnt)
                begin
                    term = longint'((longint'(i + j) * abs_delta) / n);
                    res.pcm[j] = apply_gain(frame_samples[i + j],
                        longint'(gain_now) + ((delta < 0) ? -term : term));
                end
            end
            res.lanes = cnt;
            res.last = (i + cnt >= n);
            expected_pcm_q.push_back(res);
        end
        gain_now = (gain_now + delta) & ((64'd1 << GAIN_W) - 1);
    endtask

    // Compares every result transaction with the oldest expected one.
    always @(posedge clk)
    begin
        pcm_item_t got;
        pcm_item_t want;
        bit        bad;
        if (rst_n && pcm_valid)
        begin
            got.pcm[0] = pcm_0;
            got.pcm[1] = pcm_1;
            got.pcm[2] = pcm_2;
            got.pcm[3] = pcm_3;
            got.lanes = pcm_lanes;
            got.last = pcm_last;
            if (expected_pcm_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result pcm %0d %0d %0d %0d lanes %0d last %0d",
                        got.pcm[0], got.pcm[1], got.pcm[2], got.pcm[3], got.lanes, got.last);
            end
            else
            begin
                want = expected_pcm_q.pop_front();
                bad = (got.lanes !== want.lanes) || (got.last !== want.last);
                for (int j = 0; j < LANES; j++)
                    if (got.pcm[j] !== want.pcm[j])
                        bad = 1'b1;
                if (bad)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"ERROR: pcm %0d %0d %0d %0d lanes %0d last %0d, ",
                            "expected %0d %0d %0d %0d lanes %0d last %0d"},
                            got.pcm[0], got.pcm[1], got.pcm[2], got.pcm[3], got.lanes,
                            got.last, want.pcm[0], want.pcm[1], want.pcm[2], want.pcm[3],
                            want.lanes, want.last);
                end
            end
        end
    end

    // Sends one input transaction; the sender holds start high until busy is
    // low at a rising edge. Busy is checked at the falling edge, where it is
    // stable until the next rising edge.
    task automatic send_item(input audio_item_t it);
        @(negedge clk);
        sample_0 = it.smp[0];
        sample_1 = it.smp[1];
        sample_2 = it.smp[2];
        sample_3 = it.smp[3];
        lanes_used = it.lanes;
        frame_end = it.last;
        start = 1'b1;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        predict_frame(it);
    endtask

    // Drops start about half the time, for a random number of cycles, mostly short, sometimes long.
    task automatic sender_gap();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return;
        len = (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        @(negedge clk);
        start = 1'b0;
        repeat (len - 1)
            @(negedge clk);
    endtask

    // Waits until every expected result has come and the block has had time
    // to finish a frame end that gives no result.
    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (expected_pcm_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // Writes one configuration register through the write channel.
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        case (idx)
            REG_TARGET_LEVEL:  agc_target_level = value[LEVEL_W-1:0];
            REG_MAX_GAIN:      agc_max_gain = value[GAIN_W-1:0];
            REG_RISE_FRACTION: agc_rise_fraction = value[RISE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all_regs(input logic [CFG_DATA_W-1:0] level,
                                  input logic [CFG_DATA_W-1:0] gain_cap,
                                  input logic [CFG_DATA_W-1:0] rise);
        wait_idle();
        write_reg(REG_TARGET_LEVEL, level);
        write_reg(REG_MAX_GAIN, gain_cap);
        write_reg(REG_RISE_FRACTION, rise);
    endtask

    // Random sample whose magnitude is at most 2^amp_bits, with an
    // occasional full-scale extreme.
    function automatic logic signed [SAMPLE_W-1:0] rand_sample(int amp_bits);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        if (pick < 6)
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        if (amp_bits >= SAMPLE_W)
            return SAMPLE_W'($urandom);
        return SAMPLE_W'($signed($urandom_range(0, (1 << (amp_bits + 1)) - 1))
            - (1 << amp_bits));
    endfunction

    function automatic audio_item_t make_item(int amp_bits, int unsigned lanes, bit last);
        audio_item_t it;
        for (int j = 0; j < LANES; j++)
            it.smp[j] = rand_sample(amp_bits);
        it.lanes = lanes;
        it.last = last;
        return it;
    endfunction

    // Sends one frame of n_items transactions with random lane counts; the
    // last one carries frame_end. Returns the number of items sent.
    task automatic send_frame(input int unsigned n_items, input int amp_bits,
                              output int unsigned sent);
        sent = 0;
        for (int k = 0; k < n_items; k++)
        begin
            send_item(make_item(amp_bits, $urandom_range(0, 7), k == n_items - 1));
            sender_gap();
            sent++;
        end
    endtask

    // Extremes of every field, lane counts of zero and above four, an empty
    // frame and a one-sample frame.
    task automatic test_directed_fields();
        audio_item_t it;
        it.smp[0] = {1'b0, {(SAMPLE_W-1){1'b1}}};
        it.smp[1] = {1'b1, {(SAMPLE_W-1){1'b0}}};
        it.smp[2] = '0;
        it.smp[3] = '1;
        it.lanes = 3'd4;
        it.last = 1'b0;
        send_item(it);
        it.lanes = 3'd0;
        send_item(it);
        it.smp[0] = 24'sh00_0100;
        it.smp[3] = 24'sh55_AAAA;
        it.lanes = 3'd7;
        it.last = 1'b1;
        send_item(it);
        // A frame end without stored samples must give no result.
        it.lanes = 3'd0;
        send_item(it);
        it.smp[0] = 24'sh00_0001;
        it.lanes = 3'd1;
        send_item(it);
        it.smp[0] = 24'shAA_5555;
        it.smp[1] = -24'sd256;
        it.lanes = 3'd2;
        it.last = 1'b0;
        send_item(it);
        it.lanes = 3'd5;
        it.last = 1'b1;
        send_item(it);
        it.lanes = 3'd6;
        send_item(it);
    endtask

    // Several random settings, each with a run of random frames. Quiet
    // settings let the ring empty out so that gains rise and hit the cap.
    task automatic test_random_frames(input int unsigned item_budget);
        int unsigned total;
        int unsigned sent;
        int unsigned n_items;
        int          amp_bits;
        total = 0;
        while (total < item_budget)
        begin
            write_all_regs($urandom_range(1, 32767),
                ($urandom_range(0, 3) == 0) ? 22'h3F_FFFF : $urandom_range(65536, 4194303),
                ($urandom_range(0, 5) == 0) ? 16'hFFFF : $urandom_range(0, 65535));
            amp_bits = $urandom_range(0, 3) == 0 ? SAMPLE_W : $urandom_range(4, 20);
            for (int f = 0; f < 12 && total < item_budget; f++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Noise: a stray frame end, possibly empty.
                    send_item(make_item(amp_bits, $urandom_range(0, 1), 1'b1));
                    total++;
                end
                // Rarely a frame long enough that it may run past the frame store.
                n_items = ($urandom_range(0, 29) == 0) ? $urandom_range(41, 46)
                                                       : $urandom_range(1, 8);
                send_frame(n_items, amp_bits, sent);
                total += sent;
            end
        end
    endtask

    // A fast rise; then a gain cap lowered under the held gain gives a ramped
    // fall; a frozen rise; and last the smallest settings, which pin the gain
    // low for good and so come at the end of the run.
    task automatic test_gain_corners();
        int unsigned sent;
        write_all_regs(22'd32767, 22'h3F_FFFF, 16'hFFFF);
        repeat (3)
            send_frame(2, 8, sent);
        write_all_regs(22'd32767, 22'd100000, 16'hFFFF);
        repeat (2)
            send_frame(3, 8, sent);
        write_all_regs(22'd1, 22'd4194303, 16'd0);
        repeat (2)
            send_frame(2, 12, sent);
        write_all_regs(22'd20000, 22'd1, 16'd65535);
        repeat (2)
            send_frame(2, 6, sent);
        wait_idle();
        write_reg(REG_UNUSED, 22'h2A_AAAA);
        write_all_regs(22'd0, 22'h15_5555, 16'd1);
        repeat (2)
            send_frame(2, 10, sent);
    endtask

    // Stops a hung run.
    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        agc_target_level = TARGET_LEVEL_RST;
        agc_max_gain = MAX_GAIN_RST;
        agc_rise_fraction = RISE_FRACTION_RST;
        foreach (peak_ring[h])
            peak_ring[h] = 0;
        foreach (frame_samples[i])
            frame_samples[i] = 0;
        ring_wr_ptr = 0;
        gain_now = MAX_GAIN_RST;
        frame_fill = 0;

        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;

        test_directed_fields();
        test_random_frames(300);
        test_gain_corners();

        wait_idle();
        if (mismatch_count == 0 && expected_pcm_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
